/* sv/c2p_pkg.sv */
// Shared types and constants for the conservative-to-primitive converter.
package c2p_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int LANES     = 3;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_E = 2;

  localparam logic CFG_GAS = 1'b0;
  localparam logic CFG_IHC = 1'b1;

  typedef struct packed {
    logic             bad;
    logic             last;
    logic [LANES-1:0] neg;
  } c2p_side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
    logic signed [DATA_W-1:0] temperature;
    logic                     bad_density;
    logic                     last_out;
  } c2p_res_t;

endpackage

/* sv/c2p_div_cell.sv */
// One restoring-division cell: resolves one quotient bit for three lanes.
module c2p_div_cell #(
  parameter int NumW = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [c2p_pkg::CFG_W-1:0]           d_i,
  input  logic [c2p_pkg::LANES-1:0][c2p_pkg::CFG_W-1:0] rem_i,
  input  logic [c2p_pkg::LANES-1:0][NumW-1:0] num_i,
  input  c2p_pkg::c2p_side_t                  side_i,
  output logic                                valid_o,
  output logic [c2p_pkg::CFG_W-1:0]           d_o,
  output logic [c2p_pkg::LANES-1:0][c2p_pkg::CFG_W-1:0] rem_o,
  output logic [c2p_pkg::LANES-1:0][NumW-1:0] num_o,
  output c2p_pkg::c2p_side_t                  side_o
);
  import c2p_pkg::*;

  logic                                valid_q;
  logic [CFG_W-1:0]                    d_q;
  logic [LANES-1:0][CFG_W-1:0]         rem_q, rem_d;
  logic [LANES-1:0][NumW-1:0]          num_q, num_d;
  c2p_side_t                           side_q;

  always_comb begin
    logic [CFG_W:0] trial;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      trial    = {rem_i[l], num_i[l][NumW-1]};
      ge       = (trial >= {1'b0, d_i});
      rem_d[l] = ge ? CFG_W'(trial - {1'b0, d_i}) : trial[CFG_W-1:0];
      num_d[l] = {num_i[l][NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      d_q    <= d_i;
      rem_q  <= rem_d;
      num_q  <= num_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign side_o  = side_q;

endmodule

/* sv/c2p_post.sv */
// Post-division pipeline: saturation, kinetic energy, temperature and pressure.
module c2p_post #(
  parameter int FracBits = c2p_pkg::FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [c2p_pkg::LANES-1:0][32+FracBits-1:0] q_i,
  input  logic [c2p_pkg::CFG_W-1:0]            rho_i,
  input  c2p_pkg::c2p_side_t                   side_i,
  input  logic [c2p_pkg::CFG_W-1:0]            gas_i,
  input  logic [c2p_pkg::CFG_W-1:0]            ihc_i,
  output logic                                 valid_o,
  output c2p_pkg::c2p_res_t                    res_o
);
  import c2p_pkg::*;

  localparam int DW    = 32 + FracBits;
  localparam int HW    = 63 - FracBits;
  localparam int MAXA  = (DW + 1 > 64 - FracBits) ? DW + 1 : 64 - FracBits;
  localparam int DFW   = MAXA + 1;
  localparam int RTW   = 62 - FracBits;
  localparam int STAGES = 7;

  function automatic logic signed [DATA_W-1:0] sat_q(input logic [DW-1:0] q, input logic neg);
    logic signed [DATA_W-1:0] r;
    if (neg) begin
      if (q > DW'(64'h8000_0000)) r = 32'sh8000_0000;
      else                        r = DATA_W'(DW'(0) - q);
    end else begin
      if (q > DW'(64'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else                        r = q[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] mul_sat(input logic [63:0] ph,
                                                      input logic [63:0] pl,
                                                      input logic neg);
    logic [63:0]              mag;
    logic signed [DATA_W-1:0] r;
    if (ph >= (64'd1 << (FracBits - 1))) mag = 64'h1_0000_0000;
    else mag = (ph << (32 - FracBits)) + (pl >> FracBits);
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'sh8000_0000;
      else                     r = DATA_W'(64'd0 - mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else                     r = mag[DATA_W-1:0];
    end
    return r;
  endfunction

  logic [STAGES-1:0] vld_q;
  c2p_side_t side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  logic signed [DATA_W-1:0] u1_q, v1_q, u2_q, v2_q, u3_q, v3_q, u4_q, v4_q;
  logic signed [DATA_W-1:0] u5_q, v5_q, u6_q, v6_q;
  logic signed [DW:0]       e1_q, e2_q;
  logic [CFG_W-1:0]         rho1_q;
  logic [63:0]              uu2_q, vv2_q;
  logic [2*CFG_W-1:0]       rtf2_q;
  logic [DFW-1:0]           mag3_q;
  logic                     dneg3_q, dneg4_q;
  logic [RTW-1:0]           rt3_q, rt4_q, rt5_q;
  logic [63:0]              ph4_q, pl4_q, ph6_q, pl6_q;
  logic signed [DATA_W-1:0] t5_q, t6_q;
  logic [DATA_W-1:0]        tmag5_q;
  c2p_res_t                 res7_q;

  logic [DW:0]     e_d;
  logic [63:0]     sum3;
  logic [HW-1:0]   half3;
  logic [DFW-1:0]  diff3;
  logic signed [DATA_W-1:0] t5_d;

  always_comb begin
    e_d   = side_i.neg[LANE_E] ? (DW+1)'(0) - {1'b0, q_i[LANE_E]} : {1'b0, q_i[LANE_E]};
    sum3  = uu2_q + vv2_q;
    half3 = sum3[63:FracBits+1];
    diff3 = DFW'(e2_q) - DFW'(half3);
    t5_d  = mul_sat(ph4_q, pl4_q, dneg4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      u1_q    <= sat_q(q_i[LANE_X], side_i.neg[LANE_X]);
      v1_q    <= sat_q(q_i[LANE_Y], side_i.neg[LANE_Y]);
      e1_q    <= e_d;
      rho1_q  <= rho_i;

      side2_q <= side1_q;
      u2_q    <= u1_q;
      v2_q    <= v1_q;
      e2_q    <= e1_q;
      uu2_q   <= 64'(u1_q * u1_q);
      vv2_q   <= 64'(v1_q * v1_q);
      rtf2_q  <= gas_i * rho1_q;

      side3_q <= side2_q;
      u3_q    <= u2_q;
      v3_q    <= v2_q;
      dneg3_q <= diff3[DFW-1];
      mag3_q  <= diff3[DFW-1] ? DFW'(0) - diff3 : diff3;
      rt3_q   <= rtf2_q[2*CFG_W-1:FracBits];

      side4_q <= side3_q;
      u4_q    <= u3_q;
      v4_q    <= v3_q;
      dneg4_q <= dneg3_q;
      rt4_q   <= rt3_q;
      ph4_q   <= 64'(mag3_q[DFW-1:32] * ihc_i);
      pl4_q   <= 64'(mag3_q[31:0] * ihc_i);

      side5_q <= side4_q;
      u5_q    <= u4_q;
      v5_q    <= v4_q;
      rt5_q   <= rt4_q;
      t5_q    <= t5_d;
      tmag5_q <= t5_d[DATA_W-1] ? DATA_W'(0) - DATA_W'(t5_d) : DATA_W'(t5_d);

      side6_q <= side5_q;
      u6_q    <= u5_q;
      v6_q    <= v5_q;
      t6_q    <= t5_q;
      ph6_q   <= 64'(rt5_q[RTW-1:32] * tmag5_q);
      pl6_q   <= 64'(rt5_q[31:0] * tmag5_q);

      res7_q.bad_density <= side6_q.bad;
      res7_q.last_out    <= side6_q.last;
      if (side6_q.bad) begin
        res7_q.pressure    <= '0;
        res7_q.velocity_x  <= '0;
        res7_q.velocity_y  <= '0;
        res7_q.temperature <= '0;
      end else begin
        res7_q.pressure    <= mul_sat(ph6_q, pl6_q, t6_q[DATA_W-1]);
        res7_q.velocity_x  <= u6_q;
        res7_q.velocity_y  <= v6_q;
        res7_q.temperature <= t6_q;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign res_o   = res7_q;

endmodule

/* sv/conservative_to_primitive_2d.sv */
// Top level: divider cell chain, post pipeline, output register and skid stage.
//
//  Port group   Dir  Contents
//  s_axis       in   tdata {total_energy, momentum_y, momentum_x, density}, tlast last_in
//  m_axis       out  tdata {temperature, velocity_y, velocity_x, pressure}, tuser bad_density,
//                    tlast last_out
//  cfg          in   write enable, register index, 31-bit data
//
// One request is accepted per cycle while the skid stage is empty. The divider chain has
// 32 + FracBits cells, one per quotient bit, then seven post stages and the output register.
// Reset clears all valid flags and loads the default gas constants.
// When the output stalls, a skid stage catches the next result and the whole
// pipeline holds until it drains.
module conservative_to_primitive_2d #(
  parameter int FracBits = c2p_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // density, momentum_x, momentum_y, total_energy from bit 0 up
  input  logic [4*c2p_pkg::DATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pressure, velocity_x, velocity_y, temperature from bit 0 up
  output logic [4*c2p_pkg::DATA_W-1:0]  m_axis_tdata,
  // bad_density
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [c2p_pkg::CFG_W-1:0]     cfg_data_i
);
  import c2p_pkg::*;

  localparam int DW = 32 + FracBits;
  localparam logic [CFG_W-1:0] GasReset = CFG_W'(64'd1 << FracBits);
  localparam logic [CFG_W-1:0] IhcReset = CFG_W'((64'd2 << FracBits) / 5);

  logic [CFG_W-1:0] gas_q, ihc_q;
  logic             en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gas_q <= GasReset;
      ihc_q <= IhcReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAS) gas_q <= cfg_data_i;
      if (cfg_idx_i == CFG_IHC) ihc_q <= cfg_data_i;
    end
  end

  logic signed [DATA_W-1:0] rho_in;
  logic [LANES-1:0][DATA_W-1:0] m_in;
  logic [DW:0]                 valid_c;
  logic [DW:0][CFG_W-1:0]      d_c;
  logic [DW:0][LANES-1:0][CFG_W-1:0] rem_c;
  logic [DW:0][LANES-1:0][DW-1:0]    num_c;
  c2p_side_t                   side_c [DW+1];

  always_comb begin
    rho_in         = s_axis_tdata[DATA_W-1:0];
    m_in[LANE_X]   = s_axis_tdata[2*DATA_W-1:DATA_W];
    m_in[LANE_Y]   = s_axis_tdata[3*DATA_W-1:2*DATA_W];
    m_in[LANE_E]   = s_axis_tdata[4*DATA_W-1:3*DATA_W];
    side_c[0].bad  = (rho_in <= 0);
    side_c[0].last = s_axis_tlast;
    valid_c[0]     = s_axis_tvalid;
    d_c[0]         = side_c[0].bad ? CFG_W'(1) : rho_in[CFG_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      side_c[0].neg[l] = m_in[l][DATA_W-1];
      rem_c[0][l]      = '0;
      num_c[0][l]      = {(m_in[l][DATA_W-1] ? DATA_W'(0) - m_in[l] : m_in[l]),
                          FracBits'(0)};
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_cell
    c2p_div_cell #(.NumW(DW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[k]),
      .d_i     (d_c[k]),
      .rem_i   (rem_c[k]),
      .num_i   (num_c[k]),
      .side_i  (side_c[k]),
      .valid_o (valid_c[k+1]),
      .d_o     (d_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .num_o   (num_c[k+1]),
      .side_o  (side_c[k+1])
    );
  end

  logic     post_valid;
  c2p_res_t post_res;

  c2p_post #(.FracBits(FracBits)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[DW]),
    .q_i     (num_c[DW]),
    .rho_i   (d_c[DW]),
    .side_i  (side_c[DW]),
    .gas_i   (gas_q),
    .ihc_i   (ihc_q),
    .valid_o (post_valid),
    .res_o   (post_res)
  );

  c2p_res_t out_q, out_d, skid_q, skid_d;
  logic     out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  assign en = !skid_vld_q;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (en && post_valid) begin
      if (!out_vld_q || m_axis_tready) begin
        out_d     = post_res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = post_res;
        skid_vld_d = 1'b1;
      end
    end else if (out_vld_q && m_axis_tready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.temperature, out_q.velocity_y, out_q.velocity_x, out_q.pressure};
  assign m_axis_tuser  = out_q.bad_density;
  assign m_axis_tlast  = out_q.last_out;

endmodule

/* sv/c2p_checker.sv */
// Port-level checks for the converter, bound to the top level.
module c2p_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Result data changed while stalled.");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 128'd0)
    else $error("Bad density result carries nonzero data.");

  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("Input stalled without an output stall.");

endmodule

bind conservative_to_primitive_2d c2p_checker u_c2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/conservative_to_primitive_2d_tb.sv */
// Self-checking stream testbench for the 2D conservative-to-primitive converter.
module conservative_to_primitive_2d_tb;
  import c2p_pkg::*;

  localparam int DRAIN_CYCLES = 32 + FRAC_BITS + 16;
  localparam logic [DATA_W-1:0] MAX32 = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MIN32 = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ONE   = 32'h0001_0000;

  typedef struct {
    logic [DATA_W-1:0] rho, mx, my, en;
    logic              last;
    bit                typed;
    c2p_res_t          res;
  } node_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [4*DATA_W-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [4*DATA_W-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = CFG_GAS;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  logic [CFG_W-1:0] gas_r = 31'd65536;
  logic [CFG_W-1:0] ihc_r = 31'd26214;
  c2p_res_t         primitive_q[$];
  int               mismatches = 0;
  int               send_pct = 0;
  int               recv_pct = 0;
  int               stall_left = 0;

  conservative_to_primitive_2d dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mul_frac_sat(longint unsigned m, longint unsigned b, bit neg);
    logic [127:0] prod;
    logic [127:0] mag;
    prod = {64'd0, m} * {64'd0, b};
    mag = prod >> FRAC_BITS;
    if (neg) begin
      if (mag > 128'h8000_0000) return -64'sd2147483648;
      return -longint'(mag[63:0]);
    end
    if (mag > 128'h7fff_ffff) return 64'sd2147483647;
    return longint'(mag[63:0]);
  endfunction

  function automatic c2p_res_t convert_node(logic [DATA_W-1:0] rho_b, mx_b, my_b, en_b,
                                            logic last);
    longint rho, mx, my, en, u, v, e, diff, t, p;
    longint unsigned sum, half, rt;
    c2p_res_t r;
    r = '0;
    r.last_out = last;
    rho = $signed(rho_b);
    mx = $signed(mx_b);
    my = $signed(my_b);
    en = $signed(en_b);
    if (rho <= 0) begin
      r.bad_density = 1'b1;
    end else begin
      u = clip32((mx <<< FRAC_BITS) / rho);
      v = clip32((my <<< FRAC_BITS) / rho);
      e = (en <<< FRAC_BITS) / rho;
      sum = longint'(u * u) + longint'(v * v);
      half = sum >> (FRAC_BITS + 1);
      diff = e - longint'(half);
      t = mul_frac_sat(diff < 0 ? -diff : diff, ihc_r, diff < 0);
      rt = (longint'(gas_r) * rho) >> FRAC_BITS;
      p = mul_frac_sat(rt, t < 0 ? -t : t, t < 0);
      r.pressure = p[31:0];
      r.velocity_x = u[31:0];
      r.velocity_y = v[31:0];
      r.temperature = t[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Receiver side: random or held-off tready.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    c2p_res_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (primitive_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        w = primitive_q.pop_front();
        if (m_axis_tdata[31:0] !== w.pressure) report("pressure", m_axis_tdata[31:0], w.pressure);
        if (m_axis_tdata[63:32] !== w.velocity_x)
          report("velocity_x", m_axis_tdata[63:32], w.velocity_x);
        if (m_axis_tdata[95:64] !== w.velocity_y)
          report("velocity_y", m_axis_tdata[95:64], w.velocity_y);
        if (m_axis_tdata[127:96] !== w.temperature)
          report("temperature", m_axis_tdata[127:96], w.temperature);
        if (m_axis_tuser !== w.bad_density) report("bad_density", m_axis_tuser, w.bad_density);
        if (m_axis_tlast !== w.last_out) report("last_out", m_axis_tlast, w.last_out);
      end
    end
  end

  task automatic send_node(node_row_t n);
    while ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {n.en, n.my, n.mx, n.rho};
    s_axis_tlast <= n.last;
    do @(posedge clk_i); while (!s_axis_tready);
    primitive_q.push_back(n.typed ? n.res : convert_node(n.rho, n.mx, n.my, n.en, n.last));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (primitive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GAS) gas_r = val;
    else ihc_r = val;
  endtask

  function automatic logic [DATA_W-1:0] rand_field(bit wide);
    if (wide) return $urandom();
    return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
  endfunction

  initial begin
    node_row_t rows [14];
    node_row_t n;
    c2p_res_t bad0, bad1, base;
    bad0 = '0;
    bad0.bad_density = 1'b1;
    bad1 = bad0;
    bad1.last_out = 1'b1;
    base = '0;
    base.pressure = 32'd26214;
    base.temperature = 32'd26214;
    rows = '{
      '{ONE, 0, 0, ONE, 0, 1, base},
      '{0, 5, 6, 7, 1, 1, bad1},
      '{MIN32, MAX32, MAX32, MAX32, 0, 1, bad0},
      '{32'hffff_ffff, MIN32, MIN32, MIN32, 1, 1, bad1},
      '{1, MAX32, MIN32, MAX32, 0, 0, '0},
      '{1, MIN32, MAX32, MIN32, 1, 0, '0},
      '{MAX32, MAX32, MAX32, MAX32, 0, 0, '0},
      '{MAX32, MIN32, MIN32, MIN32, 1, 0, '0},
      '{ONE, MAX32, 0, 0, 0, 0, '0},
      '{ONE, 0, MIN32, MAX32, 0, 0, '0},
      '{ONE, 32'h0002_0000, 32'hfffd_0000, 32'h0010_0000, 1, 0, '0},
      '{ONE, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, '0},
      '{32'h0000_8000, 32'hffff_0000, 32'h0000_0001, 32'hffff_ffff, 1, 0, '0},
      '{32'h7fff_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 0, 0, '0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_node(rows[i]);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin write_cfg(CFG_GAS, 31'h7fff_ffff); write_cfg(CFG_IHC, 31'h7fff_ffff); end
        1: begin write_cfg(CFG_GAS, '0); write_cfg(CFG_IHC, '0); end
        2: begin write_cfg(CFG_GAS, 31'd65536); write_cfg(CFG_IHC, 31'd26214); end
        default: begin
          write_cfg(CFG_GAS, CFG_W'($urandom_range(32'h0010_0000)));
          write_cfg(CFG_IHC, CFG_W'($urandom_range(32'h0004_0000)));
        end
      endcase
      send_pct = (ph % 3 == 0) ? 12 : (ph % 3 == 1) ? 50 : 0;
      recv_pct = (ph % 3 == 0) ? 50 : (ph % 3 == 1) ? 12 : 0;
      for (int k = 0; k < 205; k++) begin
        if (ph == 0 && k == 20) stall_left = 300;
        if (ph == 3 && k == 100) begin
          s_axis_tvalid <= 1'b0;
          while (primitive_q.size() != 0) @(posedge clk_i);
        end
        n.typed = 0;
        n.res = '0;
        n.last = 1'($urandom_range(1));
        if ($urandom_range(9) < 8) begin
          n.rho = $urandom_range(32'h0040_0000, 32'd1);
          n.mx = rand_field(0);
          n.my = rand_field(0);
          n.en = $urandom_range(32'h0100_0000);
        end else begin
          n.rho = $urandom();
          n.mx = rand_field(1);
          n.my = rand_field(1);
          n.en = rand_field(1);
        end
        send_node(n);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
